FILE: rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Sizes, request and status codes, command and result types shared by the
// front end, the back end and the top level of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 4;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_LIST_FWD   = REQ_W'(4);
  localparam logic [REQ_W-1:0] REQ_LIST_BWD   = REQ_W'(5);

  localparam logic [ST_W-1:0] ST_OK    = ST_W'(0);
  localparam logic [ST_W-1:0] ST_OVER  = ST_W'(1);
  localparam logic [ST_W-1:0] ST_UNDER = ST_W'(2);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_LIST_FWD,
    OP_LIST_BWD
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_LIST
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
    logic              last;
  } result_t;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

FILE: rtl/core/bdq_front.sv
// ----------------------------------------------------------------------------
// Bounded deque front end
// Accepts requests, decodes them into commands, drops unused codes and
// holds the commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module bdq_front
  import bdq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  input  logic                     deq_i,
  output logic                     cmd_valid_o,
  output cmd_t                     cmd_o
);

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              code_ok;
  op_e               op_dec;
  logic              push;
  logic              pop;

  always_comb begin
    code_ok = 1'b1;
    op_dec  = OP_PUSH_FRONT;
    unique case (req_type_i)
      REQ_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      REQ_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      REQ_POP_FRONT:  op_dec = OP_POP_FRONT;
      REQ_POP_BACK:   op_dec = OP_POP_BACK;
      REQ_LIST_FWD:   op_dec = OP_LIST_FWD;
      REQ_LIST_BWD:   op_dec = OP_LIST_BWD;
      default:        code_ok = 1'b0;
    endcase
  end

  assign busy        = (cnt_q == QCNT_W'(QDEPTH));
  assign push        = start && !busy && code_ok;
  assign pop         = deq_i && cmd_valid_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: op_dec, data: data_in_i};
    end
  end

endmodule

FILE: rtl/core/bdq_back.sv
// ----------------------------------------------------------------------------
// Bounded deque back end
// Executes queued commands against the ring store, keeps the front index
// and entry count, and walks the ring one entry per cycle for listings.
// ----------------------------------------------------------------------------
module bdq_back
  import bdq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CAP_W-1:0] capacity_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             deq_o,
  output result_t          res_o
);

  back_state_e       state_q, state_d;
  logic [DATA_W-1:0] store_q [DEPTH];
  logic [PTR_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              dir_q, dir_d;
  logic              done_q;
  result_t           res_q, res_d;

  logic [CNT_W-1:0]  limit;
  logic              backward;
  logic [CNT_W-1:0]  cur_idx;
  logic [CNT_W-1:0]  rd_off;
  logic [PTR_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic              list_more;
  logic              list_end;

  assign limit = (int'(capacity_i) > int'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_i);

  assign backward = (state_q == BK_LIST) ? dir_q :
                    (cmd_i.op == OP_POP_BACK || cmd_i.op == OP_LIST_BWD);
  assign cur_idx  = (state_q == BK_LIST) ? idx_q : '0;
  assign rd_off   = backward ? (count_q - CNT_W'(1) - cur_idx) : cur_idx;
  assign rd_addr  = ring_add(front_q, rd_off[PTR_W-1:0]);
  assign rd_data  = store_q[rd_addr];
  assign list_end = (cur_idx + CNT_W'(1) == count_q);

  always_comb begin
    deq_o     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = front_q;
    front_d   = front_q;
    count_d   = count_q;
    idx_d     = idx_q;
    dir_d     = dir_q;
    list_more = 1'b0;
    res_d     = '{valid: 1'b0, status: ST_OK, data: '0, last: 1'b1};
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          deq_o       = 1'b1;
          res_d.valid = 1'b1;
          unique case (cmd_i.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count_q >= limit) begin
                res_d.status = ST_OVER;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (cmd_i.op == OP_PUSH_FRONT) begin
                  wr_addr = ring_add(front_q, PTR_W'(DEPTH - 1));
                  front_d = wr_addr;
                end else begin
                  wr_addr = ring_add(front_q, count_q[PTR_W-1:0]);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count_q == '0) begin
                res_d.status = ST_UNDER;
              end else begin
                res_d.data = rd_data;
                count_d    = count_q - CNT_W'(1);
                if (cmd_i.op == OP_POP_FRONT) begin
                  front_d = ring_add(front_q, PTR_W'(1));
                end
              end
            end
            default: begin
              if (count_q == '0) begin
                res_d.status = ST_UNDER;
              end else begin
                res_d.data = rd_data;
                res_d.last = list_end;
                list_more  = !list_end;
                idx_d      = CNT_W'(1);
                dir_d      = backward;
              end
            end
          endcase
        end
      end
      BK_LIST: begin
        res_d.valid = 1'b1;
        res_d.data  = rd_data;
        res_d.last  = list_end;
        idx_d       = idx_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (list_more) state_d = BK_LIST;
      BK_LIST: if (list_end) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      dir_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      dir_q   <= dir_d;
      done_q  <= res_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (wr_en) begin
      store_q[wr_addr] <= cmd_i.data;
    end
  end

  always_comb begin
    res_o       = res_q;
    res_o.valid = done_q;
  end

endmodule

FILE: rtl/core/bounded_deque_with_status.sv
// ----------------------------------------------------------------------------
// Bounded deque with status
// Double-ended queue of signed 32-bit values in an eight-entry ring store.
//
// A request is taken on a rising edge with start high and busy low. Codes
// 0 to 5 push at the front or back, pop from the front or back, or list all
// entries forwards or backwards; codes 6 and 7 are taken and dropped.
// Each result appears on status_o, data_out_o and last_o for one cycle with
// done_o high; last_o marks the final result of a request. The receiver
// cannot stall, so results are never held back.
// Pushes and pops give one result and sustain one request per cycle while
// no listing holds the back end. A listing emits one entry per cycle from
// the ring store read port until its last entry is out. A two-deep command
// queue between the decode stage and the back end raises busy when full.
// Capacity is written through cfg_we_i and cfg_wdata_i and resets to five;
// the user must write it only while idle, which the block does not enforce.
// Reset empties the deque; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_deque_with_status
  import bdq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  output logic                     done_o,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic                     last_o
);

  logic [CAP_W-1:0] capacity_q;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             deq;
  result_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  bdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .data_in_i   (data_in_i),
    .deq_i       (deq),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  bdq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capacity_i  (capacity_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .deq_o       (deq),
    .res_o       (res)
  );

  assign done_o     = res.valid;
  assign status_o   = res.status;
  assign data_out_o = res.data;
  assign last_o     = res.last;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (data_out_o == '0 && last_o))
    else $error("Error result carries data or is not final.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("Command queue filled without a transfer in.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deq && !cmd_valid) |-> 1'b0)
    else $error("Back end took a command from an empty queue.");
`endif

endmodule
